[rtl/marching_cubes_cell_triangulator_macros.svh]
// Assertion macros for the marching-cubes cell triangulator.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef MARCHING_CUBES_CELL_TRIANGULATOR_MACROS_SVH
`define MARCHING_CUBES_CELL_TRIANGULATOR_MACROS_SVH

// Check that cond holds at every edge outside reset.
`define MCCT_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error(msg);

// Check that cause in one cycle implies effect in the next.
`define MCCT_ASSERT_NEXT(label, clk, rstn, cause, effect, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cause) |=> (effect)) \
        else $error(msg);

`endif

[rtl/mcct_pkg.sv]
// Shared types, constants and lookup tables for the marching-cubes cell triangulator.
// No dependencies.
package mcct_pkg;

    localparam int MAX_TRI    = 5;
    localparam int ROW_W      = 60;
    localparam int TRI_W      = 12;
    localparam int COORD_W    = 9;
    localparam int CNT_W      = 3;
    localparam logic [3:0] NO_EDGE = 4'hf;

    typedef logic [ROW_W-1:0]   row_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic [7:0] z;
        logic [7:0] y;
        logic [7:0] x;
    } base_t;

    typedef struct packed {
        coord_t z;
        coord_t y;
        coord_t x;
    } vtx_t;

    // Triangle table: edge nibbles from the top, unused slots hold NO_EDGE.
    localparam row_t TRI_TAB [256] = '{
        60'hfffffffffffffff, 60'h083ffffffffffff, 60'h019ffffffffffff, 60'h183981fffffffff,
        60'h12affffffffffff, 60'h08312afffffffff, 60'h92a029fffffffff, 60'h2832a8a98ffffff,
        60'h3b2ffffffffffff, 60'h0b28b0fffffffff, 60'h19023bfffffffff, 60'h1b219b98bffffff,
        60'h3a1ba3fffffffff, 60'h0a108a8baffffff, 60'h3903b9ba9ffffff, 60'h98aa8bfffffffff,
        60'h478ffffffffffff, 60'h430734fffffffff, 60'h019847fffffffff, 60'h419471731ffffff,
        60'h12a847fffffffff, 60'h34730412affffff, 60'h92a902847ffffff, 60'h2a9297273794fff,
        60'h8473b2fffffffff, 60'hb47b24204ffffff, 60'h90184723bffffff, 60'h47b94b9b2921fff,
        60'h3a13ba784ffffff, 60'h1ba14b1047b4fff, 60'h47890b9bab03fff, 60'h47b4b99baffffff,
        60'h954ffffffffffff, 60'h954083fffffffff, 60'h054150fffffffff, 60'h854835315ffffff,
        60'h12a954fffffffff, 60'h30812a495ffffff, 60'h52a542402ffffff, 60'h2a5325354348fff,
        60'h95423bfffffffff, 60'h0b208b495ffffff, 60'h05401523bffffff, 60'h21525828b485fff,
        60'ha3ba13954ffffff, 60'h4950818a18bafff, 60'h54050b5bab03fff, 60'h54858aa8bffffff,
        60'h978579fffffffff, 60'h930953573ffffff, 60'h078017157ffffff, 60'h153357fffffffff,
        60'h978957a12ffffff, 60'ha12950530573fff, 60'h802825857a52fff, 60'h2a5253357ffffff,
        60'h7957893b2ffffff, 60'h95797292027bfff, 60'h23b018178157fff, 60'hb21b17715ffffff,
        60'h958857a13a3bfff, 60'h5705097b010aba0, 60'hba0b03a50807570, 60'hba57b5fffffffff,
        60'ha65ffffffffffff, 60'h0835a6fffffffff, 60'h9015a6fffffffff, 60'h1831985a6ffffff,
        60'h165261fffffffff, 60'h165126308ffffff, 60'h965906026ffffff, 60'h598582526328fff,
        60'h23ba65fffffffff, 60'hb08b20a65ffffff, 60'h01923b5a6ffffff, 60'h5a61929b298bfff,
        60'h63b653513ffffff, 60'h08b0b50515b6fff, 60'h3b6036065059fff, 60'h65969bb98ffffff,
        60'h5a6478fffffffff, 60'h43047365affffff, 60'h1905a6847ffffff, 60'ha65197173794fff,
        60'h612651478ffffff, 60'h125526304347fff, 60'h847905065026fff, 60'h739794329596269,
        60'h3b2784a65ffffff, 60'h5a647242027bfff, 60'h01947823b5a6fff, 60'h9219b294b7b45a6,
        60'h8473b53515b6fff, 60'h51b5b610b7b404b, 60'h059065036b63847, 60'h65969b4797b9fff,
        60'ha4964afffffffff, 60'h4a649a083ffffff, 60'ha01a60640ffffff, 60'h83181686461afff,
        60'h149124264ffffff, 60'h308129249264fff, 60'h024426fffffffff, 60'h832824426ffffff,
        60'ha49a64b23ffffff, 60'h08228b49a4a6fff, 60'h3b201606461afff, 60'h64161a48121b8b1,
        60'h964936913b63fff, 60'h8b1810b61914641, 60'h3b6360064ffffff, 60'h648b68fffffffff,
        60'h7a678a89affffff, 60'h0730a709a67afff, 60'ha671a7178180fff, 60'ha67a71173ffffff,
        60'h126168189867fff, 60'h269291679093739, 60'h780706602ffffff, 60'h732672fffffffff,
        60'h23ba68a89867fff, 60'h20727b09767a9a7, 60'h1801781a767a23b, 60'hb21b17a61671fff,
        60'h896867916b63136, 60'h091b67fffffffff, 60'h7807063b0b60fff, 60'h7b6ffffffffffff,
        60'h76bffffffffffff, 60'h308b76fffffffff, 60'h019b76fffffffff, 60'h819831b76ffffff,
        60'ha126b7fffffffff, 60'h12a3086b7ffffff, 60'h2902a96b7ffffff, 60'h6b72a3a83a98fff,
        60'h723627fffffffff, 60'h708760620ffffff, 60'h276237019ffffff, 60'h162186198876fff,
        60'ha76a17137ffffff, 60'ha7617a187108fff, 60'h03707a0a96a7fff, 60'h76a7a88a9ffffff,
        60'h684b86fffffffff, 60'h36b306046ffffff, 60'h86b846901ffffff, 60'h946963931b36fff,
        60'h6846b82a1ffffff, 60'h12a30b06b046fff, 60'h4b846b0292a9fff, 60'ha93a32943b36463,
        60'h823842462ffffff, 60'h042462fffffffff, 60'h190234246438fff, 60'h194142246ffffff,
        60'h8138618466a1fff, 60'ha10a06604ffffff, 60'h4634386a3039a93, 60'ha946a4fffffffff,
        60'h49576bfffffffff, 60'h083495b76ffffff, 60'h50154076bffffff, 60'hb76834354315fff,
        60'h954a1276bffffff, 60'h6b712a083495fff, 60'h76b54a42a402fff, 60'h348354325a52b76,
        60'h723762549ffffff, 60'h954086062687fff, 60'h362376150540fff, 60'h628687218485158,
        60'h954a16176137fff, 60'h16a176107870954, 60'h40a4a503a6a737a, 60'h76a7a854a48afff,
        60'h6956b9b89ffffff, 60'h36b063056095fff, 60'h0b805b01556bfff, 60'h6b3635531ffffff,
        60'h12a95b9b8b56fff, 60'h0b306b09656912a, 60'hb85b56805a52025, 60'h6b36352a3a53fff,
        60'h589528562382fff, 60'h956960062ffffff, 60'h158180568382628, 60'h156216fffffffff,
        60'h13616a386569896, 60'ha10a06950560fff, 60'h03856afffffffff, 60'ha56ffffffffffff,
        60'hb5a75bfffffffff, 60'hb5ab75830ffffff, 60'h5b75ab190ffffff, 60'ha75ab7981831fff,
        60'hb12b71751ffffff, 60'h08312717572bfff, 60'h9759279022b7fff, 60'h75272b592328982,
        60'h25a235375ffffff, 60'h820852875a25fff, 60'h9015a35373a2fff, 60'h982921872a25752,
        60'h135375fffffffff, 60'h087071175ffffff, 60'h903935537ffffff, 60'h987597fffffffff,
        60'h5845a8ab8ffffff, 60'h5045b05abb30fff, 60'h01984a8aba45fff, 60'hab4a45b34941314,
        60'h2512852b8458fff, 60'h04b0b345b2b151b, 60'h0250592b5458b85, 60'h9452b3fffffffff,
        60'h25a352345384fff, 60'h5a2524420ffffff, 60'h3a235a385458019, 60'h5a2524192942fff,
        60'h845853351ffffff, 60'h045105fffffffff, 60'h845853905035fff, 60'h945ffffffffffff,
        60'h4b749b9abffffff, 60'h0834979b79abfff, 60'h1ab1b414074bfff, 60'h3143481a474bab4,
        60'h4b79b492b912fff, 60'h9749b791b2b1083, 60'hb74b42240ffffff, 60'hb74b42834324fff,
        60'h29a279237749fff, 60'h9a7974a27870207, 60'h37a3a274a1a040a, 60'h1a2874fffffffff,
        60'h491417713ffffff, 60'h491417081871fff, 60'h403743fffffffff, 60'h487ffffffffffff,
        60'h9a8ab8fffffffff, 60'h30939bb9affffff, 60'h01a0a88abffffff, 60'h31ab3afffffffff,
        60'h12b1b99b8ffffff, 60'h30939b1292b9fff, 60'h02b80bfffffffff, 60'h32bffffffffffff,
        60'h23828aa89ffffff, 60'h9a2092fffffffff, 60'h23828a0181a8fff, 60'h1a2ffffffffffff,
        60'h138918fffffffff, 60'h091ffffffffffff, 60'h038ffffffffffff, 60'hfffffffffffffff
    };

    // Count triangles in a row: a slot is used when its first edge is valid.
    function automatic cnt_t tri_count(input row_t row);
        cnt_t n;
        n = '0;
        for (int k = 0; k < MAX_TRI; k++) begin
            if (row[ROW_W-1-TRI_W*k -: 4] != NO_EDGE) begin
                n = n + cnt_t'(1);
            end
        end
        return n;
    endfunction

    // Edge midpoint offset from the cube base in half-voxel units, {z,y,x}.
    function automatic logic [5:0] edge_mid(input logic [3:0] e);
        logic [5:0] r;
        unique case (e)
            4'd0:    r = {2'd0, 2'd0, 2'd1};
            4'd1:    r = {2'd0, 2'd1, 2'd2};
            4'd2:    r = {2'd0, 2'd2, 2'd1};
            4'd3:    r = {2'd0, 2'd1, 2'd0};
            4'd4:    r = {2'd2, 2'd0, 2'd1};
            4'd5:    r = {2'd2, 2'd1, 2'd2};
            4'd6:    r = {2'd2, 2'd2, 2'd1};
            4'd7:    r = {2'd2, 2'd1, 2'd0};
            4'd8:    r = {2'd1, 2'd0, 2'd0};
            4'd9:    r = {2'd1, 2'd0, 2'd2};
            4'd10:   r = {2'd1, 2'd2, 2'd2};
            4'd11:   r = {2'd1, 2'd2, 2'd0};
            default: r = 6'd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/mcct_vertex.sv]
// Edge midpoint vertex: base coordinate plus edge offset, saturated at the volume limit.
// Depends on mcct_pkg.
module mcct_vertex #(
    parameter int HALF_LIMIT = 510
) (
    input  mcct_pkg::base_t    base,
    input  logic [3:0]         edge_id,
    output mcct_pkg::vtx_t     vtx
);
    import mcct_pkg::*;

    localparam logic [9:0] LIMIT = 10'(HALF_LIMIT);

    logic [5:0] off;
    logic [9:0] sx, sy, sz;

    // Scale base to half-voxels and add the midpoint offset
    always_comb begin
        off = edge_mid(edge_id);
        sx  = {1'b0, base.x, 1'b0} + 10'(off[1:0]);
        sy  = {1'b0, base.y, 1'b0} + 10'(off[3:2]);
        sz  = {1'b0, base.z, 1'b0} + 10'(off[5:4]);
    end

    // Clamp each axis to the limit
    always_comb begin
        vtx.x = (sx > LIMIT) ? LIMIT[COORD_W-1:0] : sx[COORD_W-1:0];
        vtx.y = (sy > LIMIT) ? LIMIT[COORD_W-1:0] : sy[COORD_W-1:0];
        vtx.z = (sz > LIMIT) ? LIMIT[COORD_W-1:0] : sz[COORD_W-1:0];
    end

endmodule

[rtl/marching_cubes_cell_triangulator.sv]
// Marching-cubes cell triangulator, binary volume with midpoint vertices.
//
// Input channel (s_): one beat per cube; tdata carries corner_bits, base_x,
// base_y, base_z. The case row is looked up as the beat is taken and held in
// a cube register.
// Output channel (m_): one beat per triangle, three vertices in half-voxel
// units; tlast marks the final triangle of a cube. Cubes 0 and 255 give none.
// The first triangle of a cube passes through the cube register, then the output register.
// Throughput: a cube holds the cube register until its last triangle is loaded,
// one triangle computed per cycle while the receiver does not stall;
// the next cube is taken in the cycle its last triangle is loaded.
// The output register decouples the sides: while the receiver stalls, the
// current triangle holds on m_ and the cube register stops advancing.
// Reset (aresetn low, synchronous) empties both registers; no sweep needed.
// Coordinates saturate at 2*(VOLUME_SIZE-1), capped at 511.
module marching_cubes_cell_triangulator #(
    parameter int VOLUME_SIZE = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // corner_bits, base_x, base_y, base_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,    // ax, ay, az, bx, by_coord, bz, cx, cy, cz, zero pad
    output logic        m_tlast     // last_triangle
);
    import mcct_pkg::*;

    `include "marching_cubes_cell_triangulator_macros.svh"

    localparam int HALF_RAW   = 2 * (VOLUME_SIZE - 1);
    localparam int HALF_LIMIT = (HALF_RAW > 511) ? 511 : HALF_RAW;

    logic   cube_valid_reg;
    row_t   row_reg;
    cnt_t   cnt_reg;
    base_t  base_reg;
    logic   load_out, cube_done, take_in;
    row_t   row_in;
    vtx_t   va, vb, vc;

    // Look up the case row for an incoming cube
    assign row_in = TRI_TAB[s_tdata[7:0]];

    // Handshake and advance conditions
    assign load_out  = cube_valid_reg && (cnt_reg != '0) && (!m_tvalid || m_tready);
    assign cube_done = cube_valid_reg &&
                       ((cnt_reg == '0) || (load_out && cnt_reg == cnt_t'(1)));
    assign s_tready  = !cube_valid_reg || cube_done;
    assign take_in   = s_tvalid && s_tready;

    // Hold the cube, shift one triangle out per emitted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cube_valid_reg <= 1'b0;
        end else if (take_in) begin
            cube_valid_reg <= 1'b1;
            row_reg        <= row_in;
            cnt_reg        <= tri_count(row_in);
            base_reg       <= {s_tdata[31:24], s_tdata[23:16], s_tdata[15:8]};
        end else if (cube_done) begin
            cube_valid_reg <= 1'b0;
        end else if (load_out) begin
            cnt_reg <= cnt_reg - cnt_t'(1);
            row_reg <= row_reg << TRI_W;
        end
    end

    // Three vertices of the current triangle
    mcct_vertex #(.HALF_LIMIT(HALF_LIMIT)) u_vtx_a (
        .base(base_reg), .edge_id(row_reg[ROW_W-1 -: 4]), .vtx(va)
    );
    mcct_vertex #(.HALF_LIMIT(HALF_LIMIT)) u_vtx_b (
        .base(base_reg), .edge_id(row_reg[ROW_W-5 -: 4]), .vtx(vb)
    );
    mcct_vertex #(.HALF_LIMIT(HALF_LIMIT)) u_vtx_c (
        .base(base_reg), .edge_id(row_reg[ROW_W-9 -: 4]), .vtx(vc)
    );

    // Output register: load a triangle, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (load_out) begin
            m_tvalid <= 1'b1;
            m_tlast  <= (cnt_reg == cnt_t'(1));
            m_tdata  <= {7'd0, vc.z, vc.y, vc.x, vb.z, vb.y, vb.x, va.z, va.y, va.x};
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
    end

    `MCCT_ASSERT_ALWAYS(a_cnt_range, aclk, aresetn,
        !cube_valid_reg || cnt_reg <= cnt_t'(MAX_TRI), "triangle count out of range")
    `MCCT_ASSERT_NEXT(a_last_marks_end, aclk, aresetn,
        load_out && cnt_reg == cnt_t'(1), m_tvalid && m_tlast, "final triangle not marked")
    `MCCT_ASSERT_ALWAYS(a_vtx_limit, aclk, aresetn,
        !m_tvalid || m_tdata[8:0] <= 9'(HALF_LIMIT), "vertex beyond volume limit")

endmodule
